// ===== rtl/scee_pkg.sv =====
// Shared types, constants and helpers for the switch change event encoder.
`default_nettype none

package scee_pkg;

    localparam logic [7:0] PORT_D_MASK   = 8'h3F;
    localparam logic [7:0] PORT_B_MASK   = 8'h0C;
    localparam int         PORT_B_SHIFT  = 4;
    localparam logic [5:0] CODE_MAKE     = 6'h10;
    localparam logic [5:0] CODE_BREAK    = 6'h20;
    localparam logic [7:0] WORD_ALL_ONES = 8'hFF;
    localparam int         QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] word;
        logic [7:0] delta;
    } scee_entry_t;

    function automatic logic [7:0] assemble_word(input logic [7:0] pd, input logic [7:0] pb);
        assemble_word = (pd & PORT_D_MASK) | ((pb & PORT_B_MASK) << PORT_B_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scee_front.sv =====
// Front end: accept samples, assemble the switch word and queue changed words.
`default_nettype none

module scee_front
    import scee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  port_d_pins,
    input  wire logic [7:0]  port_b_pins,
    input  wire logic        queue_full,
    output logic             push,
    output scee_entry_t      push_entry
);

    logic [7:0] prev_word_reg;
    logic [7:0] prev_word_next;
    logic [7:0] word;
    logic       accept;

    assign word     = assemble_word(port_d_pins, port_b_pins);
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    assign push_entry.word  = word;
    assign push_entry.delta = word ^ prev_word_reg;
    assign push             = accept && (push_entry.delta != 8'd0);

    assign prev_word_next = accept ? word : prev_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_word_reg <= WORD_ALL_ONES;
        end
        else
        begin
            prev_word_reg <= prev_word_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scee_queue.sv =====
// Short FIFO of changed switch words between front and back end.
`default_nettype none

module scee_queue
    import scee_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire scee_entry_t  push_entry,
    output logic              full,
    input  wire logic         pop,
    output scee_entry_t       pop_entry,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    scee_entry_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scee_back.sv =====
// Back end: serialize changed bits into make/break events, lowest bit first.
`default_nettype none

module scee_back
    import scee_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         queue_empty,
    input  wire scee_entry_t  queue_entry,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [5:0]        event_code,
    output logic [3:0]        key_number,
    output logic              released,
    output logic [7:0]        pressed_mask,
    output logic              last_event
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic [7:0] word_reg;
    logic [7:0] word_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [5:0] event_code_reg;
    logic [3:0] key_number_reg;
    logic       released_reg;
    logic [7:0] pressed_mask_reg;
    logic       last_event_reg;

    logic [7:0] low_bit;
    logic [7:0] remaining;
    logic [3:0] key;
    logic       up;
    logic       is_last;
    logic       advance;

    assign low_bit   = pending_reg & (~pending_reg + 8'd1);
    assign remaining = pending_reg & ~low_bit;
    assign is_last   = (remaining == 8'd0);
    assign up        = |(low_bit & word_reg);
    assign advance   = (pending_reg != 8'd0) && (!out_valid_reg || !out_stall);
    assign pop       = !queue_empty && ((pending_reg == 8'd0) || (advance && is_last));

    always_comb
    begin
        key = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (low_bit[i])
            begin
                key = 4'(i + 1);
            end
        end
    end

    always_comb
    begin
        pending_next = pending_reg;
        word_next    = word_reg;
        if (pop)
        begin
            pending_next = queue_entry.delta;
            word_next    = queue_entry.word;
        end
        else if (advance)
        begin
            pending_next = remaining;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (advance)
        begin
            event_code_reg   <= (up ? CODE_BREAK : CODE_MAKE) | {2'b00, key};
            key_number_reg   <= key;
            released_reg     <= up;
            pressed_mask_reg <= ~word_reg;
            last_event_reg   <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_code   = event_code_reg;
    assign key_number   = key_number_reg;
    assign released     = released_reg;
    assign pressed_mask = pressed_mask_reg;
    assign last_event   = last_event_reg;

endmodule

`default_nettype wire

// ===== rtl/switch_change_event_encoder_top.sv =====
// Top level of the switch change event encoder.
//
// Input channel (in_valid / in_stall): one transaction carries one sample of
// port_d_pins and port_b_pins. Switches 1..6 are port D bits 0..5, switches
// 7..8 are port B bits 2..3, all active low.
// Output channel (out_valid / out_stall): one transaction per changed switch,
// lowest key first, with event_code (0x10 + key on make, 0x20 + key on break),
// key_number, released, pressed_mask and last_event on the final event.
// A sample that changes nothing produces no transaction.
// The first event of a sample passes the change queue, the pending register
// and the output register. Throughput: one event per cycle from the serializer
// while out_stall is low, so a sample with n changed switches (at most 8)
// gives n events; a new sample is accepted every cycle while the change queue
// has room. Reset clears the queue and the output valid flag and sets the kept
// switch word to all ones (all released). When the receiver stalls, the output
// register holds its transaction; the queue then fills and in_stall rises.
`default_nettype none

module switch_change_event_encoder_top
    import scee_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  port_d_pins,
    input  wire logic [7:0]  port_b_pins,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       event_code,
    output logic [3:0]       key_number,
    output logic             released,
    output logic [7:0]       pressed_mask,
    output logic             last_event
);

    logic        push;
    scee_entry_t push_entry;
    logic        queue_full;
    logic        queue_empty;
    logic        pop;
    scee_entry_t pop_entry;

    scee_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .port_d_pins (port_d_pins),
        .port_b_pins (port_b_pins),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    scee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty)
    );

    scee_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .queue_entry  (pop_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .key_number   (key_number),
        .released     (released),
        .pressed_mask (pressed_mask),
        .last_event   (last_event)
    );

endmodule

`default_nettype wire

// ===== rtl/scee_checker.sv =====
// Port-level checker for the switch change event encoder, bound to the top level.
`default_nettype none

module scee_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [5:0] event_code,
    input wire logic [3:0] key_number,
    input wire logic       released,
    input wire logic [7:0] pressed_mask
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_number >= 4'd1) && (key_number <= 4'd8))
        else $error("key number out of range");

    a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_code[3:0] == key_number) && (event_code[5] == released)
                      && (event_code[4] == !released))
        else $error("event code does not match key and direction");

    a_mask_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((pressed_mask >> (key_number - 4'd1)) & 8'd1)
                       == {7'd0, !released}))
        else $error("pressed mask disagrees with event direction");

endmodule

bind switch_change_event_encoder_top scee_checker u_scee_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_code   (event_code),
    .key_number   (key_number),
    .released     (released),
    .pressed_mask (pressed_mask)
);

`default_nettype wire

// ===== bench/scee_event_checker.sv =====
// Checker for the switch change event encoder: predicts each event and compares it.
module scee_event_checker
    import scee_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] port_d_pins,
    input  wire logic [7:0] port_b_pins,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [5:0] event_code,
    input  wire logic [3:0] key_number,
    input  wire logic       released,
    input  wire logic [7:0] pressed_mask,
    input  wire logic       last_event,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic [5:0] code;
        logic [3:0] key;
        logic       up;
        logic [7:0] mask;
        logic       last;
    } switch_event_t;

    switch_event_t expected_events[$];
    switch_event_t head;
    logic [7:0]    kept_word;
    int            errors;

    task automatic queue_switch_events(input logic [7:0] pd, input logic [7:0] pb);
        logic [7:0]    word;
        logic [7:0]    delta;
        switch_event_t ev;
        begin
            word  = {pb[3:2], pd[5:0]};
            delta = word ^ kept_word;
            for (int i = 0; i < 8; i++)
            begin
                if (delta[i])
                begin
                    ev.key  = 4'(i + 1);
                    ev.up   = word[i];
                    ev.code = (word[i] ? CODE_BREAK : CODE_MAKE) | 6'(i + 1);
                    ev.mask = ~word;
                    ev.last = ((delta >> (i + 1)) == 8'd0);
                    expected_events.push_back(ev);
                end
            end
            kept_word = word;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
        begin
            if (exp !== act)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, act);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_events.delete();
            kept_word = WORD_ALL_ONES;
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none actual code %h",
                             $time, event_code);
                    errors++;
                end
                else
                begin
                    head = expected_events.pop_front();
                    check_field("event_code", 8'(head.code), 8'(event_code));
                    check_field("key_number", 8'(head.key), 8'(key_number));
                    check_field("released", 8'(head.up), 8'(released));
                    check_field("pressed_mask", head.mask, pressed_mask);
                    check_field("last_event", 8'(head.last), 8'(last_event));
                end
            end
            if (in_valid && !in_stall)
                queue_switch_events(port_d_pins, port_b_pins);
            fail_count <= errors;
            pending <= expected_events.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the switch change event encoder: drives samples and gives the verdict.
module tb;
    import scee_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] port_d_pins = 8'h00;
    logic [7:0] port_b_pins = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [5:0] event_code;
    logic [3:0] key_number;
    logic       released;
    logic [7:0] pressed_mask;
    logic       last_event;

    int         fail_count;
    int         pending;
    logic       hold_req = 1'b0;
    logic [7:0] switch_word = WORD_ALL_ONES;
    int         burst_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    switch_change_event_encoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .port_d_pins  (port_d_pins),
        .port_b_pins  (port_b_pins),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .key_number   (key_number),
        .released     (released),
        .pressed_mask (pressed_mask),
        .last_event   (last_event)
    );

    scee_event_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .port_d_pins  (port_d_pins),
        .port_b_pins  (port_b_pins),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .key_number   (key_number),
        .released     (released),
        .pressed_mask (pressed_mask),
        .last_event   (last_event),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    task automatic offer_sample(input logic [7:0] pd, input logic [7:0] pb);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            port_d_pins <= pd;
            port_b_pins <= pb;
            in_valid <= 1'b1;
            switch_word = {pb[3:2], pd[5:0]};
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic send_word(input logic [7:0] w);
        logic [7:0] noise;
        begin
            noise = 8'($urandom);
            offer_sample({noise[7:6], w[5:0]}, {noise[5:2], w[7:6], noise[1:0]});
        end
    endtask

    // receiver: stall pattern in spans, with one long hold-off on request
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        forever
        begin
            span = $urandom_range(32, 96);
            mode = $urandom_range(0, 3);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_req && !held)
                begin
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (120) @(posedge clk);
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #(12 * 300000);
        $display("** switch_change_event_encoder_top: FAILED **");
        $finish;
    end

    initial
    begin
        int         pick;
        logic [7:0] w;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_sample(8'hFF, 8'hFF);
        offer_sample(8'h00, 8'h00);
        offer_sample(8'h00, 8'h00);
        offer_sample(8'hFF, 8'hFF);
        offer_sample(8'hC0, 8'hF3);
        offer_sample(8'h3F, 8'h0C);
        for (int k = 0; k < 8; k++)
            send_word(~(8'h01 << k));
        send_word(8'hFF);
        send_word(8'hAA);
        send_word(8'h55);
        send_word(8'h80);
        send_word(8'h01);
        offer_sample(8'hFF, 8'hFF);

        for (int n = 0; n < 140; n++)
        begin
            if (n == 50)
                hold_req <= 1'b1;
            pick = $urandom_range(0, 9);
            w = switch_word;
            if (pick < 7)
            begin
                repeat ($urandom_range(1, 3))
                    w[$urandom_range(0, 7)] ^= 1'b1;
                send_word(w);
            end
            else if (pick == 7)
                send_word(w);
            else if (pick == 8)
                send_word(8'($urandom));
            else
                offer_sample(8'($urandom), 8'($urandom));
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("** switch_change_event_encoder_top: PASSED **");
        else
            $display("** switch_change_event_encoder_top: FAILED **");
        $finish;
    end

endmodule

// ===== switch_change_event_encoder_top.f =====
rtl/scee_pkg.sv
rtl/scee_front.sv
rtl/scee_queue.sv
rtl/scee_back.sv
rtl/switch_change_event_encoder_top.sv
rtl/scee_checker.sv
bench/scee_event_checker.sv
bench/tb.sv
